### rtl/mtat_pkg.sv
// mtat_pkg: shared constants and register codes for the multi-turn angle tracker
// no dependencies; imported by multi_turn_angle_tracker, mtat_checker and testbench

package mtat_pkg;

  // field widths
  localparam int unsigned ANGLE_W  = 12;
  localparam int unsigned POS_W    = 17;
  localparam int unsigned TURNS_W  = 5;
  localparam int unsigned DBAND_W  = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;

  // default parameter values
  localparam int unsigned COUNTS_PER_TURN_DEF = 4096;
  localparam int unsigned TURN_LIMIT_DEF      = 15;

  // clamp for the unwrapped position
  localparam int unsigned POS_MAX = 65535;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WRAP_UPPER = 2'd0,
    CFG_WRAP_LOWER = 2'd1,
    CFG_DEADBAND   = 2'd2
  } cfg_idx_e;

  // register reset values
  localparam logic [ANGLE_W-1:0] WRAP_UPPER_RST = 12'd2596;
  localparam logic [ANGLE_W-1:0] WRAP_LOWER_RST = 12'd1596;
  localparam logic [DBAND_W-1:0] DEADBAND_RST   = 8'd2;

endpackage

### rtl/multi_turn_angle_tracker.sv
// multi_turn_angle_tracker: top level, turn counting and deadband hold of a single-turn angle
// depends on mtat_pkg

// The block takes one angle word per clock while not stalled and returns one result word per
// angle word. An accepted word passes the input register, then the result register; a stalled
// result register can hold it in the input register. Sustained rate is one word per cycle
// while the result side is not stalled; the turn count, turn offset and held position loop
// through their own registers, which allows that rate. A full result register that is stalled
// stalls the input side in the same cycle once the input register also holds a word. The first
// word after reset only primes the previous angle. Turn offset is kept as a running multiple
// of COUNTS_PER_TURN, so no multiplier is needed. Configuration writes are always ready and
// are meant to happen while the block is idle; unknown indexes are ignored.
module multi_turn_angle_tracker
  import mtat_pkg::*;
#(
  parameter int unsigned COUNTS_PER_TURN = COUNTS_PER_TURN_DEF,
  parameter int unsigned TURN_LIMIT      = TURN_LIMIT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  // angle input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ANGLE_W-1:0]           angle_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [POS_W-1:0]      position_o,
  output logic signed [TURNS_W-1:0]    turns_o,
  output logic                         updated_o
);

  // internal widths derived from the parameters
  localparam int unsigned TURN_W  = $clog2(TURN_LIMIT + 1) + 1;
  localparam int unsigned OFS_W   = $clog2(TURN_LIMIT * COUNTS_PER_TURN + 1) + 1;
  localparam int unsigned UNW_W   = ((OFS_W > POS_W) ? OFS_W : POS_W) + 1;
  localparam int unsigned CLMP_W  = POS_W + 1;
  localparam int unsigned DIFF_W  = POS_W + 2;

  localparam logic signed [TURN_W-1:0] TURN_MAX = TURN_W'(TURN_LIMIT);
  localparam logic signed [TURN_W-1:0] TURN_MIN = -TURN_W'(TURN_LIMIT);
  localparam logic signed [OFS_W-1:0]  OFS_STEP = OFS_W'(COUNTS_PER_TURN);
  localparam logic signed [UNW_W-1:0]  UNW_MAX  = UNW_W'(POS_MAX);
  localparam logic signed [UNW_W-1:0]  UNW_MIN  = -UNW_W'(POS_MAX);

  // configuration registers
  logic [ANGLE_W-1:0] wrap_upper_q;
  logic [ANGLE_W-1:0] wrap_lower_q;
  logic [DBAND_W-1:0] deadband_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_upper_q <= WRAP_UPPER_RST;
      wrap_lower_q <= WRAP_LOWER_RST;
      deadband_q   <= DEADBAND_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_WRAP_UPPER: wrap_upper_q <= cfg_data_i;
        CFG_WRAP_LOWER: wrap_lower_q <= cfg_data_i;
        CFG_DEADBAND:   deadband_q   <= cfg_data_i[DBAND_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: stage 1 advances whenever the result register is free or draining
  logic out_valid_q;
  logic s1_valid_q;
  logic out_blocked;
  logic in_fire;
  logic s1_fire;

  assign out_blocked = out_valid_q && out_stall_i;
  assign in_stall_o  = s1_valid_q && out_blocked;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign s1_fire     = s1_valid_q && !out_blocked;

  // input register
  logic [ANGLE_W-1:0] s1_angle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_angle_q <= angle_i;
    end
  end

  // tracker state
  logic                      primed_q;
  logic [ANGLE_W-1:0]        prev_angle_q;
  logic signed [TURN_W-1:0]  turn_q, turn_d;
  logic signed [OFS_W-1:0]   offset_q, offset_d;
  logic signed [POS_W-1:0]   held_q, held_d;
  logic                      upd;

  logic                      wrap_up;
  logic                      wrap_down;
  logic signed [UNW_W-1:0]   unwrapped;
  logic signed [CLMP_W-1:0]  unw_clamped;
  logic signed [DIFF_W-1:0]  diff;
  logic [DIFF_W-1:0]         diff_abs;

  // turn detection, unwrap, clamp and deadband compare
  always_comb begin
    wrap_up   = (prev_angle_q > wrap_upper_q) && (s1_angle_q <= wrap_lower_q);
    wrap_down = !wrap_up && (s1_angle_q > wrap_upper_q) && (prev_angle_q <= wrap_lower_q);

    turn_d   = turn_q;
    offset_d = offset_q;
    if (primed_q) begin
      if (wrap_up && (turn_q < TURN_MAX)) begin
        turn_d   = turn_q + TURN_W'(1);
        offset_d = offset_q + OFS_STEP;
      end else if (wrap_down && (turn_q > TURN_MIN)) begin
        turn_d   = turn_q - TURN_W'(1);
        offset_d = offset_q - OFS_STEP;
      end
    end

    unwrapped = signed'(UNW_W'(s1_angle_q)) + UNW_W'(offset_d);
    if (unwrapped > UNW_MAX) begin
      unw_clamped = CLMP_W'(UNW_MAX);
    end else if (unwrapped < UNW_MIN) begin
      unw_clamped = CLMP_W'(UNW_MIN);
    end else begin
      unw_clamped = CLMP_W'(unwrapped);
    end

    diff     = DIFF_W'(unw_clamped) - DIFF_W'(held_q);
    diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

    upd    = primed_q && (diff_abs >= DIFF_W'(deadband_q));
    held_d = upd ? POS_W'(unw_clamped) : held_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q     <= 1'b0;
      prev_angle_q <= '0;
      turn_q       <= '0;
      offset_q     <= '0;
      held_q       <= '0;
    end else if (s1_fire) begin
      primed_q     <= 1'b1;
      prev_angle_q <= s1_angle_q;
      turn_q       <= turn_d;
      offset_q     <= offset_d;
      held_q       <= held_d;
    end
  end

  // result register
  logic signed [POS_W-1:0]   position_q;
  logic signed [TURNS_W-1:0] turns_q;
  logic                      updated_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      position_q <= -held_d;
      turns_q    <= TURNS_W'(turn_d);
      updated_q  <= upd;
    end
  end

  assign out_valid_o = out_valid_q;
  assign position_o  = position_q;
  assign turns_o     = turns_q;
  assign updated_o   = updated_q;

endmodule

### rtl/mtat_checker.sv
// mtat_checker: port-level assertions for multi_turn_angle_tracker, and the bind that attaches it
// depends on mtat_pkg and on the top level's port list

module mtat_checker
  import mtat_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic signed [POS_W-1:0]   position_o,
  input logic signed [TURNS_W-1:0] turns_o,
  input logic                      updated_o
);

  // last delivered position and turn count (held position starts at zero)
  logic signed [POS_W-1:0]   last_pos_q;
  logic signed [TURNS_W-1:0] last_turns_q;
  logic signed [TURNS_W-1:0] turn_step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pos_q   <= '0;
      last_turns_q <= '0;
    end else if (out_valid_o && !out_stall_i) begin
      last_pos_q   <= position_o;
      last_turns_q <= turns_o;
    end
  end

  assign turn_step = turns_o - last_turns_q;

  // a stalled word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(position_o) && $stable(turns_o)
      && $stable(updated_o))
    else $error("stalled result word changed");

  // input side only stalls behind a stalled full result register
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // position only moves on a word flagged as updated
  a_pos_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !updated_o |-> position_o == last_pos_q)
    else $error("position changed without update flag");

  // turn count moves by at most one turn per word
  a_turn_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> turn_step == TURNS_W'(0) || turn_step == TURNS_W'(1)
      || turn_step == -TURNS_W'(1))
    else $error("turn count jumped by more than one");

endmodule

bind multi_turn_angle_tracker mtat_checker u_mtat_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .position_o  (position_o),
  .turns_o     (turns_o),
  .updated_o   (updated_o)
);

### tb/sv/testbench.sv
// testbench: self-checking bench for the multi-turn angle tracker, random bursts and stalls
// depends on mtat_pkg and multi_turn_angle_tracker; an inline predictor checks every result word

module testbench;
  import mtat_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TURN_MAX       = int'(TURN_LIMIT_DEF);
  localparam int TURN_SPAN      = int'(COUNTS_PER_TURN_DEF);
  localparam int POS_LIMIT      = int'(POS_MAX);
  localparam int IDLE_LIMIT     = 2000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  typedef struct packed {
    logic signed [POS_W-1:0]   position;
    logic signed [TURNS_W-1:0] turns;
    logic                      updated;
  } result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [CFG_IDX_W-1:0]      cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]     cfg_data_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic [ANGLE_W-1:0]        angle_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [POS_W-1:0]   position_o;
  logic signed [TURNS_W-1:0] turns_o;
  logic                      updated_o;

  // pending angle words and predicted result words
  logic [ANGLE_W-1:0] angle_words[$];
  result_t            predicted_words[$];

  // predictor state and register copies
  logic [ANGLE_W-1:0] upper_thr = WRAP_UPPER_RST;
  logic [ANGLE_W-1:0] lower_thr = WRAP_LOWER_RST;
  logic [DBAND_W-1:0] dband     = DEADBAND_RST;
  logic [ANGLE_W-1:0] pred_prev = '0;
  int                 pred_turns = 0;
  int                 pred_held = 0;
  bit                 pred_primed = 1'b0;

  int errors = 0;
  int last_angle = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_pct = 0;
  int stall_hold = 0;
  int idle_cycles = 0;

  multi_turn_angle_tracker i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .angle_i     (angle_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .position_o  (position_o),
    .turns_o     (turns_o),
    .updated_o   (updated_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // turn counting, clamp and deadband hold for one accepted angle word
  function automatic void track_angle(input logic [ANGLE_W-1:0] a);
    result_t r;
    int      unwrapped;
    int      delta;
    r.updated = 1'b0;
    if (!pred_primed) begin
      pred_primed = 1'b1;
    end else begin
      // the increment test wins when both jumps match
      if (pred_prev > upper_thr && a <= lower_thr) begin
        if (pred_turns < TURN_MAX) pred_turns++;
      end else if (a > upper_thr && pred_prev <= lower_thr) begin
        if (pred_turns > -TURN_MAX) pred_turns--;
      end
      unwrapped = int'(a) + TURN_SPAN * pred_turns;
      if (unwrapped > POS_LIMIT) unwrapped = POS_LIMIT;
      if (unwrapped < -POS_LIMIT) unwrapped = -POS_LIMIT;
      delta = unwrapped - pred_held;
      if (delta < 0) delta = -delta;
      if (delta >= int'(dband)) begin
        pred_held = unwrapped;
        r.updated = 1'b1;
      end
    end
    pred_prev = a;
    r.position = POS_W'(-pred_held);
    r.turns = TURNS_W'(pred_turns);
    predicted_words.push_back(r);
  endfunction

  task automatic push_angle(input int a);
    angle_words.push_back(ANGLE_W'(a));
    last_angle = a;
  endtask

  // steady rotation from the last queued angle, wrapping modulo one turn
  task automatic rotate(input int n, input int step, input int dir);
    for (int i = 0; i < n; i++) begin
      push_angle((last_angle + dir * step + TURN_SPAN) % TURN_SPAN);
    end
  endtask

  // mostly rotations with random speed and direction, some noise and extremes
  task automatic add_random(input int n);
    int left;
    int seg;
    int kind;
    int step;
    left = n;
    while (left > 0) begin
      kind = $urandom_range(0, 99);
      seg = $urandom_range(4, 30);
      if (seg > left) seg = left;
      if (kind < 70) begin
        step = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(50, 1500);
        rotate(seg, step, $urandom_range(0, 1) ? 1 : -1);
      end else if (kind < 85) begin
        for (int i = 0; i < seg; i++) push_angle($urandom_range(0, 4095));
      end else begin
        for (int i = 0; i < seg; i++) begin
          push_angle($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(4088, 4095));
        end
      end
      left -= seg;
    end
  endtask

  // wait until every queued word went in and every predicted word came out
  task automatic drain();
    while (angle_words.size() != 0 || in_valid_i || predicted_words.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // one register write, mirrored into the predictor once it is taken
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_WRAP_UPPER: upper_thr = data;
      CFG_WRAP_LOWER: lower_thr = data;
      CFG_DEADBAND:   dband = data[DBAND_W-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // sequence of phases, each under its own register setting
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: priming, single wraps both ways, deadband edge, threshold edges
    push_angle(4095);
    push_angle(0);
    push_angle(4095);
    push_angle(4094);
    push_angle(4093);
    push_angle(2596);
    push_angle(1596);
    push_angle(2597);
    push_angle(1597);
    push_angle(2597);
    push_angle(0);
    push_angle(2048);
    push_angle(1);
    push_angle(4095);
    add_random(130);
    drain();

    // zero deadband, thresholds at the far ends so no wrap is seen
    cfg_write(CFG_DEADBAND, 12'hF00);
    cfg_write(CFG_WRAP_UPPER, 12'd4095);
    cfg_write(CFG_WRAP_LOWER, 12'd0);
    push_angle(0);
    push_angle(0);
    push_angle(4095);
    push_angle(0);
    add_random(70);
    drain();

    // crossed thresholds so both jump tests hold, widest deadband
    cfg_write(CFG_WRAP_UPPER, 12'd0);
    cfg_write(CFG_WRAP_LOWER, 12'd4095);
    cfg_write(CFG_DEADBAND, 12'h0FF);
    push_angle(5);
    push_angle(0);
    push_angle(7);
    push_angle(0);
    push_angle(4095);
    add_random(70);
    drain();

    // random ordered settings, plus writes to the unused index
    for (int p = 0; p < 3; p++) begin
      cfg_write(CFG_WRAP_UPPER, 12'($urandom_range(2048, 4095)));
      cfg_write(CFG_WRAP_LOWER, 12'($urandom_range(0, 2047)));
      cfg_write(CFG_DEADBAND, 12'($urandom_range(0, 4095)));
      cfg_write(CFG_SPARE_IDX, 12'($urandom_range(0, 4095)));
      add_random(80);
      drain();
    end

    // back to the reset setting, drive the turn count up towards its upper limit and back down
    cfg_write(CFG_WRAP_UPPER, WRAP_UPPER_RST);
    cfg_write(CFG_WRAP_LOWER, WRAP_LOWER_RST);
    cfg_write(CFG_DEADBAND, 12'(DEADBAND_RST));
    rotate(80, 1000, 1);
    rotate(80, 1000, -1);
    add_random(60);
    drain();

    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // input driver: bursts of words with random gaps, payload held while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      angle_i    <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (angle_words.size() != 0) begin
        in_valid_i <= 1'b1;
        angle_i    <= angle_words.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // accepted angle words feed the predictor
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) track_angle(angle_i);
  end

  // result stall pattern: stretches of random density, some with no stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_hold == 0) begin
        stall_pct = 25 * $urandom_range(0, 3);
        stall_hold = $urandom_range(20, 120);
      end else begin
        stall_hold--;
      end
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // result monitor: compare each accepted word with the oldest prediction
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_words.size() == 0) begin
        errors++;
        $display("%0t: result word expected none actual position %0d turns %0d updated %0b",
                 $time, position_o, turns_o, updated_o);
      end else begin
        want = predicted_words.pop_front();
        if (want.position !== position_o || want.turns !== turns_o
            || want.updated !== updated_o) begin
          errors++;
          if (want.position !== position_o) begin
            $display("%0t: position expected %0d actual %0d", $time, want.position,
                     position_o);
          end
          if (want.turns !== turns_o) begin
            $display("%0t: turns expected %0d actual %0d", $time, want.turns, turns_o);
          end
          if (want.updated !== updated_o) begin
            $display("%0t: updated expected %0b actual %0b", $time, want.updated,
                     updated_o);
          end
        end
      end
    end
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
          || (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

endmodule
